>>> rtl/pbts_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pbts_pkg
// Shared codes, command and status types of the bitmap task scheduler.
// ---------------------------------------------------------------------------
package pbts_pkg;

  // width of slot fields on the ports
  localparam int PORT_SLOT_W = 5;
  localparam logic [PORT_SLOT_W-1:0] NO_TASK = 5'd17;

  // event codes
  localparam logic [2:0] ACT_CREATE = 3'd0;
  localparam logic [2:0] ACT_YIELD  = 3'd1;
  localparam logic [2:0] ACT_SLEEP  = 3'd2;
  localparam logic [2:0] ACT_TICK   = 3'd3;
  localparam logic [2:0] ACT_SCHED  = 3'd4;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  // task modes
  localparam logic [1:0] MODE_READY    = 2'd0;
  localparam logic [1:0] MODE_RUNNING  = 2'd1;
  localparam logic [1:0] MODE_SLEEPING = 2'd2;

  // datapath operations
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_ACCEPT,
    OP_REJECT,
    OP_CREATE,
    OP_ENQ_NEW,
    OP_YIELD,
    OP_DIV_START,
    OP_SLEEP_APPLY,
    OP_SCHED,
    OP_TICK,
    OP_RESULT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       reject;
    logic       div_done;
    logic       tick_end;
  } stat_t;

endpackage

>>> rtl/priority_bitmap_task_scheduler_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// priority_bitmap_task_scheduler_unit
// Bitmap priority task scheduler: round-robin ready queues per level.
// ---------------------------------------------------------------------------
// States after decode: unknown or ignored go straight to the result; schedule,
// create then enqueue, yield then schedule, sleep then schedule, tick walk.
// Sleep is set by the reciprocal divider; tick by the slot walk, one slot per
// cycle. One event word is in flight at a time; the next is taken while the
// result word waits.
// Synchronous reset: idle task 0 ready at the idle level, nothing running.
module priority_bitmap_task_scheduler_unit #(
  parameter int MAX_TASKS   = 17,
  parameter int PRIO_LEVELS = 32,
  parameter int IDLE_LEVEL  = 31,
  parameter int TICK_MS     = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [4:0]  priority_req,
  input  logic [31:0] sleep_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        switched,
  output logic [4:0]  previous_task,
  output logic [4:0]  running_task,
  output logic [4:0]  created_task,
  output logic        resched_pending,
  output logic [31:0] ready_mask
);

  pbts_pkg::cmd_t  cmd;
  pbts_pkg::stat_t st;

  // sequencer
  pbts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .st        (st)
  );

  // tables and queues
  pbts_dpath #(
    .MAX_TASKS   (MAX_TASKS),
    .PRIO_LEVELS (PRIO_LEVELS),
    .IDLE_LEVEL  (IDLE_LEVEL),
    .TICK_MS     (TICK_MS)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .action          (action),
    .priority_req    (priority_req),
    .sleep_ms        (sleep_ms),
    .status          (status),
    .switched        (switched),
    .previous_task   (previous_task),
    .running_task    (running_task),
    .created_task    (created_task),
    .resched_pending (resched_pending),
    .ready_mask      (ready_mask)
  );

endmodule

>>> rtl/pbts_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pbts_div
// Division by a constant: reciprocal multiply, then one correction step.
// Quotient is registered after the multiply, estimate and correction steps.
// ---------------------------------------------------------------------------
module pbts_div #(
  parameter int DIVISOR = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  output logic [31:0] quotient,
  output logic        busy
);

  // reciprocal scaled so that it fits in 32 bits and never overestimates
  localparam int          SH    = $clog2(DIVISOR);
  localparam int          K     = 31 + SH;
  localparam logic [31:0] RECIP = 32'((64'd1 << K) / 64'(DIVISOR));
  localparam logic [31:0] DIV_C = 32'(DIVISOR);

  logic [1:0]  step;
  logic [31:0] num;
  logic [63:0] prod;
  logic [31:0] q_est;
  logic [31:0] rem;

  // estimate is low by at most one
  assign busy = step != 2'd0;
  assign rem  = num - q_est * DIV_C;

  // multiply, take the estimate, then correct it
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 2'd0;
    end else if (start) begin
      step <= 2'd2;
      num  <= dividend;
      prod <= 64'(dividend) * 64'(RECIP);
    end else if (step == 2'd2) begin
      q_est <= 32'(prod >> K);
      step  <= 2'd1;
    end else if (step == 2'd1) begin
      quotient <= q_est + 32'(rem >= DIV_C);
      step     <= 2'd0;
    end
  end

endmodule

>>> rtl/pbts_dpath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pbts_dpath
// Task tables, ready queues, ready bitmap and result word registers.
// ---------------------------------------------------------------------------
module pbts_dpath #(
  parameter int MAX_TASKS   = 17,
  parameter int PRIO_LEVELS = 32,
  parameter int IDLE_LEVEL  = 31,
  parameter int TICK_MS     = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pbts_pkg::cmd_t                cmd,
  output pbts_pkg::stat_t               st,
  input  logic [2:0]                    action,
  input  logic [4:0]                    priority_req,
  input  logic [31:0]                   sleep_ms,
  output logic [1:0]                    status,
  output logic                          switched,
  output logic [pbts_pkg::PORT_SLOT_W-1:0] previous_task,
  output logic [pbts_pkg::PORT_SLOT_W-1:0] running_task,
  output logic [pbts_pkg::PORT_SLOT_W-1:0] created_task,
  output logic                          resched_pending,
  output logic [31:0]                   ready_mask
);

  localparam int SW = $clog2(MAX_TASKS);
  localparam int TW = $clog2(MAX_TASKS + 1);
  localparam int LW = $clog2(PRIO_LEVELS);

  // leading zero count over the bitmap, nibble first
  function automatic logic [5:0] lzc32(input logic [31:0] v);
    logic       fn;
    logic       fb;
    logic [2:0] ni;
    logic [1:0] bi;
    logic [3:0] nib;
    fn = 1'b0;
    fb = 1'b0;
    ni = '0;
    bi = '0;
    for (int i = 0; i < 8; i++) begin
      if (!fn && v[31-4*i -: 4] != 4'd0) begin
        fn = 1'b1;
        ni = 3'(i);
      end
    end
    nib = v[31-4*ni -: 4];
    for (int j = 0; j < 4; j++) begin
      if (!fb && nib[3-j]) begin
        fb = 1'b1;
        bi = 2'(j);
      end
    end
    return {fn, ni, bi};
  endfunction

  // latched event word
  logic [2:0]  act_r;
  logic [4:0]  prio_r;
  logic [31:0] ms_r;
  logic [pbts_pkg::PORT_SLOT_W-1:0] prev_r;
  logic [1:0]  status_r;
  logic        sw_r;
  logic [SW-1:0] created_r;
  logic [TW-1:0] tick_idx;

  // scheduler state
  logic [SW-1:0] current_slot;
  logic          current_valid;
  logic [TW-1:0] task_total;
  logic [4:0]    task_level  [MAX_TASKS];
  logic [1:0]    task_mode   [MAX_TASKS];
  logic [31:0]   sleep_count [MAX_TASKS];
  logic [SW-1:0] link_fwd    [MAX_TASKS];
  logic [SW-1:0] link_bwd    [MAX_TASKS];
  logic [SW-1:0] level_head  [PRIO_LEVELS];
  logic [31:0]   ready_bits;
  logic          resched_flag;

  logic [SW-1:0] a_slot;
  logic [4:0]    lv_a;
  logic [1:0]    mode_a;
  logic [SW-1:0] lf_a;
  logic [31:0]   cnt_a;
  logic [31:0]   cnt_dec;
  logic [5:0]    pick;
  logic          pick_found;
  logic [4:0]    pick_lv;
  logic [LW-1:0] lh_addr;
  logic [SW-1:0] head;
  logic [SW-1:0] lb_addr;
  logic [SW-1:0] lb_v;
  logic [4:0]    lv_bit;
  logic          lv_empty;
  logic          tick_hit;
  logic          tick_wake;
  logic          do_enq;
  logic [SW-1:0] nx;
  logic          sched_sw;
  logic [1:0]    reject_code;
  logic [31:0]   quo;
  logic          div_busy;
  logic [31:0]   sleep_len;

  pbts_div #(
    .DIVISOR (TICK_MS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == pbts_pkg::OP_DIV_START),
    .dividend (ms_r),
    .quotient (quo),
    .busy     (div_busy)
  );

  // one read address per table, chosen by the operation
  always_comb begin
    a_slot = current_slot;
    if (cmd.op == pbts_pkg::OP_ENQ_NEW) begin
      a_slot = created_r;
    end else if (cmd.op == pbts_pkg::OP_TICK) begin
      a_slot = tick_idx[SW-1:0];
    end
  end

  assign lv_a      = task_level[a_slot];
  assign mode_a    = task_mode[a_slot];
  assign lf_a      = link_fwd[a_slot];
  assign cnt_a     = sleep_count[a_slot];
  assign cnt_dec   = cnt_a - 32'd1;
  assign tick_hit  = (mode_a == pbts_pkg::MODE_SLEEPING) && (cnt_a != 32'd0);
  assign tick_wake = tick_hit && (cnt_dec == 32'd0);
  assign do_enq    = (cmd.op == pbts_pkg::OP_ENQ_NEW) ||
                     ((cmd.op == pbts_pkg::OP_TICK) && tick_wake);

  // highest ready level and its queue head
  assign pick       = lzc32(ready_bits);
  assign pick_found = pick[5];
  assign pick_lv    = pick[4:0];
  assign lh_addr    = (cmd.op == pbts_pkg::OP_SCHED) ? pick_lv[LW-1:0] : lv_a[LW-1:0];
  assign head       = level_head[lh_addr];
  assign lb_addr    = do_enq ? head : a_slot;
  assign lb_v       = link_bwd[lb_addr];
  assign lv_bit     = 5'd31 - lv_a;
  assign lv_empty   = !ready_bits[lv_bit];
  assign nx         = pick_found ? head : '0;
  assign sched_sw   = !(current_valid && (nx == current_slot));
  assign sleep_len  = (quo == 32'd0) ? 32'd1 : quo;

  // rejection check of the latched event
  always_comb begin
    reject_code = pbts_pkg::ST_DONE;
    unique case (act_r)
      pbts_pkg::ACT_CREATE: begin
        if ({1'b0, prio_r} >= 6'(PRIO_LEVELS)) begin
          reject_code = pbts_pkg::ST_IGNORED;
        end else if (task_total >= TW'(MAX_TASKS)) begin
          reject_code = pbts_pkg::ST_FULL;
        end
      end
      pbts_pkg::ACT_SLEEP: begin
        if (ms_r == 32'd0 || !current_valid || mode_a == pbts_pkg::MODE_SLEEPING) begin
          reject_code = pbts_pkg::ST_IGNORED;
        end
      end
      pbts_pkg::ACT_YIELD, pbts_pkg::ACT_TICK, pbts_pkg::ACT_SCHED: begin
        reject_code = pbts_pkg::ST_DONE;
      end
      default: begin
        reject_code = pbts_pkg::ST_IGNORED;
      end
    endcase
  end

  assign st.action   = act_r;
  assign st.reject   = reject_code != pbts_pkg::ST_DONE;
  assign st.div_done = !div_busy;
  assign st.tick_end = tick_idx >= task_total;

  // state updates per operation
  always_ff @(posedge clk) begin
    if (rst) begin
      current_slot  <= '0;
      current_valid <= 1'b0;
      task_total    <= TW'(1);
      task_level[0] <= 5'(IDLE_LEVEL);
      task_mode[0]  <= pbts_pkg::MODE_READY;
      link_fwd[0]   <= '0;
      link_bwd[0]   <= '0;
      level_head[IDLE_LEVEL] <= '0;
      ready_bits    <= 32'd1 << (31 - IDLE_LEVEL);
      resched_flag  <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        sleep_count[i] <= '0;
      end
    end else begin
      unique case (cmd.op)
        pbts_pkg::OP_ACCEPT: begin
          act_r     <= action;
          prio_r    <= priority_req;
          ms_r      <= sleep_ms;
          prev_r    <= current_valid ? pbts_pkg::PORT_SLOT_W'(current_slot)
                                     : pbts_pkg::NO_TASK;
          status_r  <= pbts_pkg::ST_DONE;
          sw_r      <= 1'b0;
          created_r <= '0;
          tick_idx  <= '0;
        end
        pbts_pkg::OP_REJECT: begin
          status_r <= reject_code;
        end
        pbts_pkg::OP_CREATE: begin
          created_r  <= task_total[SW-1:0];
          task_total <= task_total + TW'(1);
          task_level[task_total[SW-1:0]]  <= prio_r;
          sleep_count[task_total[SW-1:0]] <= '0;
          if (current_valid && prio_r < lv_a) begin
            resched_flag <= 1'b1;
          end
        end
        pbts_pkg::OP_YIELD: begin
          if (current_valid && mode_a != pbts_pkg::MODE_SLEEPING) begin
            level_head[lv_a[LW-1:0]] <= lf_a;
          end
        end
        pbts_pkg::OP_SLEEP_APPLY: begin
          sleep_count[current_slot] <= sleep_len;
          task_mode[current_slot]   <= pbts_pkg::MODE_SLEEPING;
          if (lf_a == current_slot) begin
            ready_bits[lv_bit] <= 1'b0;
          end else begin
            link_fwd[lb_v] <= lf_a;
            link_bwd[lf_a] <= lb_v;
            if (head == current_slot) begin
              level_head[lv_a[LW-1:0]] <= lf_a;
            end
          end
          link_fwd[current_slot] <= current_slot;
          link_bwd[current_slot] <= current_slot;
        end
        pbts_pkg::OP_SCHED: begin
          resched_flag <= 1'b0;
          if (sched_sw) begin
            if (current_valid && mode_a == pbts_pkg::MODE_RUNNING) begin
              task_mode[current_slot] <= pbts_pkg::MODE_READY;
            end
            current_slot  <= nx;
            current_valid <= 1'b1;
            task_mode[nx] <= pbts_pkg::MODE_RUNNING;
            sw_r          <= 1'b1;
          end
        end
        pbts_pkg::OP_TICK: begin
          tick_idx <= tick_idx + TW'(1);
          if (tick_hit) begin
            sleep_count[a_slot] <= cnt_dec;
            if (tick_wake) begin
              resched_flag <= 1'b1;
            end
          end
        end
        pbts_pkg::OP_RESULT: begin
          status          <= status_r;
          switched        <= sw_r;
          previous_task   <= prev_r;
          running_task    <= current_valid ? pbts_pkg::PORT_SLOT_W'(current_slot) : '0;
          created_task    <= pbts_pkg::PORT_SLOT_W'(created_r);
          resched_pending <= resched_flag;
          ready_mask      <= ready_bits;
        end
        pbts_pkg::OP_IDLE, pbts_pkg::OP_ENQ_NEW, pbts_pkg::OP_DIV_START: begin
        end
        default: begin
        end
      endcase

      // tail insert into the level queue
      if (do_enq) begin
        task_mode[a_slot]  <= pbts_pkg::MODE_READY;
        ready_bits[lv_bit] <= 1'b1;
        if (lv_empty) begin
          level_head[lv_a[LW-1:0]] <= a_slot;
          link_fwd[a_slot] <= a_slot;
          link_bwd[a_slot] <= a_slot;
        end else begin
          link_fwd[a_slot] <= head;
          link_bwd[a_slot] <= lb_v;
          link_fwd[lb_v]   <= a_slot;
          link_bwd[head]   <= a_slot;
        end
      end
    end
  end

  // running slot is always a created slot
  a_cur_created: assert property (@(posedge clk) disable iff (rst)
    current_valid |-> (TW'(current_slot) < task_total))
    else $error("running slot beyond task table");

  // table count stays within bounds
  a_total_range: assert property (@(posedge clk) disable iff (rst)
    (task_total != '0) && (task_total <= TW'(MAX_TASKS)))
    else $error("task count out of range");

  // a scheduling pass leaves a task running and the request cleared
  a_sched_after: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == pbts_pkg::OP_SCHED) |=> (current_valid && !resched_flag))
    else $error("scheduling pass left no running task");

endmodule

>>> rtl/pbts_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pbts_ctrl
// Event sequencer: decodes one event word and steps the datapath through it.
// ---------------------------------------------------------------------------
module pbts_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output pbts_pkg::cmd_t  cmd,
  input  pbts_pkg::stat_t st
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CREATE,
    S_CREATE_ENQ,
    S_YIELD,
    S_SLEEP,
    S_SLEEP_DIV,
    S_SLEEP_APPLY,
    S_SCHED,
    S_TICK,
    S_FINISH
  } state_t;

  state_t state;
  logic   out_free;

  assign in_stall = state != S_IDLE;
  assign out_free = !out_valid || !out_stall;

  // command per state
  always_comb begin
    cmd.op = pbts_pkg::OP_IDLE;
    unique case (state)
      S_IDLE:        cmd.op = in_valid ? pbts_pkg::OP_ACCEPT : pbts_pkg::OP_IDLE;
      S_DECODE:      cmd.op = st.reject ? pbts_pkg::OP_REJECT : pbts_pkg::OP_IDLE;
      S_CREATE:      cmd.op = pbts_pkg::OP_CREATE;
      S_CREATE_ENQ:  cmd.op = pbts_pkg::OP_ENQ_NEW;
      S_YIELD:       cmd.op = pbts_pkg::OP_YIELD;
      S_SLEEP:       cmd.op = pbts_pkg::OP_DIV_START;
      S_SLEEP_DIV:   cmd.op = pbts_pkg::OP_IDLE;
      S_SLEEP_APPLY: cmd.op = pbts_pkg::OP_SLEEP_APPLY;
      S_SCHED:       cmd.op = pbts_pkg::OP_SCHED;
      S_TICK:        cmd.op = st.tick_end ? pbts_pkg::OP_IDLE : pbts_pkg::OP_TICK;
      S_FINISH:      cmd.op = out_free ? pbts_pkg::OP_RESULT : pbts_pkg::OP_IDLE;
      default:       cmd.op = pbts_pkg::OP_IDLE;
    endcase
  end

  // state and result word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (st.reject) begin
            state <= S_FINISH;
          end else begin
            unique case (st.action)
              pbts_pkg::ACT_CREATE: state <= S_CREATE;
              pbts_pkg::ACT_YIELD:  state <= S_YIELD;
              pbts_pkg::ACT_SLEEP:  state <= S_SLEEP;
              pbts_pkg::ACT_TICK:   state <= S_TICK;
              pbts_pkg::ACT_SCHED:  state <= S_SCHED;
              default:              state <= S_FINISH;
            endcase
          end
        end
        S_CREATE:      state <= S_CREATE_ENQ;
        S_CREATE_ENQ:  state <= S_FINISH;
        S_YIELD:       state <= S_SCHED;
        S_SLEEP:       state <= S_SLEEP_DIV;
        S_SLEEP_DIV: begin
          if (st.div_done) begin
            state <= S_SLEEP_APPLY;
          end
        end
        S_SLEEP_APPLY: state <= S_SCHED;
        S_SCHED:       state <= S_FINISH;
        S_TICK: begin
          if (st.tick_end) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // an accepted word keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous word in flight");

  // result load raises valid and frees the input side
  a_finish_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_free) |=> (out_valid && !in_stall))
    else $error("result word not presented");

endmodule
